// ===== hw/rtl/psd_pkg.sv =====
// package for the ppm-sum decoder: constants, register indexes and request types
// used by every module of the block; depends on nothing
`default_nettype none

package psd_pkg;

    // frame storage size
    localparam int MAX_CHANNELS = 8;
    localparam int IDX_W        = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = 5;
    localparam int WIDTH_W      = 16;
    localparam int TIME_W       = 32;
    localparam int CHIDX_W      = 4;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    // register reset values
    localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RST = 16'd2700;
    localparam logic [WIDTH_W-1:0] VALID_LOW_RST      = 16'd700;
    localparam logic [WIDTH_W-1:0] VALID_HIGH_RST     = 16'd2300;
    localparam logic [CNT_W-1:0]   MIN_FRAME_RST      = 5'd5;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_THRESHOLD = 2'd0,
        REG_VALID_LOW      = 2'd1,
        REG_VALID_HIGH     = 2'd2,
        REG_MIN_FRAME      = 2'd3
    } t_reg_idx;

    // pulse tracker phases
    typedef enum logic [1:0] {
        PH_INITIAL = 2'd0,
        PH_ZERO    = 2'd1,
        PH_ONE     = 2'd2
    } t_phase;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] sample_time;
    } t_in_req;

    typedef struct packed {
        logic [CHIDX_W-1:0] channel_index;
        logic [WIDTH_W-1:0] channel_width;
        logic [CNT_W-1:0]   frame_channels;
        logic               last_of_frame;
    } t_out_req;

    typedef struct packed {
        logic [WIDTH_W-1:0] sync_threshold;
        logic [WIDTH_W-1:0] valid_low;
        logic [WIDTH_W-1:0] valid_high;
        logic [CNT_W-1:0]   min_frame_channels;
    } t_cfg;

    // one completed low-then-high pulse
    typedef struct packed {
        logic               valid;
        logic [WIDTH_W-1:0] width;
    } t_pulse;

    // frame hand-over from the decoder to the emitter
    typedef struct packed {
        logic                                  emit;
        logic [CNT_W-1:0]                      count;
        logic [MAX_CHANNELS-1:0][WIDTH_W-1:0]  words;
    } t_frame;

endpackage

`default_nettype wire

// ===== hw/rtl/psd_pulse.sv =====
// edge timing and three-phase pulse tracker
// depends on psd_pkg
`default_nettype none

module psd_pulse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire psd_pkg::t_in_req i_req,
    output psd_pkg::t_pulse       o_pulse
);

    logic                         r_primed, n_primed;
    logic                         r_last_level, n_last_level;
    logic [psd_pkg::WIDTH_W-1:0]  r_edge_time, n_edge_time;
    logic [psd_pkg::WIDTH_W-1:0]  r_first_half, n_first_half;
    psd_pkg::t_phase              r_phase, n_phase;
    logic                         level_change;
    logic [psd_pkg::WIDTH_W-1:0]  delta;

    // edge detection and interval since the previous edge, low 16 bits
    assign level_change = r_primed && (i_req.pin_level != r_last_level);
    assign delta = i_req.sample_time[psd_pkg::WIDTH_W-1:0] - r_edge_time;

    // next state
    always_comb begin
        n_primed     = r_primed;
        n_last_level = r_last_level;
        n_edge_time  = r_edge_time;
        n_first_half = r_first_half;
        n_phase      = r_phase;
        if (!r_primed) begin
            n_primed     = 1'b1;
            n_last_level = i_req.pin_level;
            n_edge_time  = i_req.sample_time[psd_pkg::WIDTH_W-1:0];
        end else begin
            n_last_level = i_req.pin_level;
            if (level_change) begin
                n_edge_time = i_req.sample_time[psd_pkg::WIDTH_W-1:0];
                unique case (r_phase)
                    psd_pkg::PH_ZERO: begin
                        if (!i_req.pin_level) begin
                            n_first_half = delta;
                            n_phase      = psd_pkg::PH_ONE;
                        end
                    end
                    psd_pkg::PH_ONE: begin
                        if (i_req.pin_level) begin
                            n_phase = psd_pkg::PH_ZERO;
                        end
                    end
                    default: begin
                        n_phase = psd_pkg::PH_ZERO;
                    end
                endcase
            end
        end
    end

    // outputs: a pulse completes on the rising edge in phase one
    always_comb begin
        o_pulse.valid = level_change && (r_phase == psd_pkg::PH_ONE) && i_req.pin_level;
        o_pulse.width = r_first_half + delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed     <= 1'b0;
            r_last_level <= 1'b0;
            r_edge_time  <= '0;
            r_first_half <= '0;
            r_phase      <= psd_pkg::PH_INITIAL;
        end else if (i_adv) begin
            r_primed     <= n_primed;
            r_last_level <= n_last_level;
            r_edge_time  <= n_edge_time;
            r_first_half <= n_first_half;
            r_phase      <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/psd_frame.sv =====
// ppm-sum frame decoder: channel store, counter and sync handling
// depends on psd_pkg
`default_nettype none

module psd_frame (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire psd_pkg::t_cfg   i_cfg,
    input  wire psd_pkg::t_pulse i_pulse,
    output psd_pkg::t_frame      o_frame
);

    logic [psd_pkg::MAX_CHANNELS-1:0][psd_pkg::WIDTH_W-1:0] r_store;
    logic [psd_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_unsynced, n_unsynced;
    logic                      is_sync;
    logic                      in_window;
    logic                      store_we;
    logic [psd_pkg::CNT_W-1:0] count_inc;

    assign is_sync   = i_pulse.width >= i_cfg.sync_threshold;
    assign in_window = (i_pulse.width > i_cfg.valid_low) && (i_pulse.width < i_cfg.valid_high);
    assign store_we  = i_pulse.valid && !is_sync && !r_unsynced && in_window;
    assign count_inc = r_count + psd_pkg::CNT_W'(1);

    // frame hand-over on a sync with enough channels
    always_comb begin
        o_frame.emit  = i_pulse.valid && is_sync && !r_unsynced
                        && (r_count >= i_cfg.min_frame_channels)
                        && (r_count != '0);
        o_frame.count = r_count;
        o_frame.words = r_store;
    end

    // counter and sync state
    always_comb begin
        n_count    = r_count;
        n_unsynced = r_unsynced;
        if (i_pulse.valid) begin
            if (is_sync) begin
                n_count    = '0;
                n_unsynced = 1'b0;
            end else if (store_we) begin
                if (count_inc >= psd_pkg::CNT_W'(psd_pkg::MAX_CHANNELS)) begin
                    n_count    = '0;
                    n_unsynced = 1'b1;
                end else begin
                    n_count = count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_unsynced <= 1'b0;
        end else if (i_adv) begin
            r_count    <= n_count;
            r_unsynced <= n_unsynced;
        end
    end

    // channel store, no reset
    always_ff @(posedge i_clk) begin
        if (i_adv && store_we) begin
            r_store[r_count[psd_pkg::IDX_W-1:0]] <= i_pulse.width;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/psd_emit.sv =====
// frame emitter: snapshot buffer and output register, one channel per request
// depends on psd_pkg
`default_nettype none

module psd_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire psd_pkg::t_frame i_frame,
    output logic                 o_busy,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output psd_pkg::t_out_req    o_out_req
);

    logic [psd_pkg::MAX_CHANNELS-1:0][psd_pkg::WIDTH_W-1:0] r_buf;
    logic                      r_busy;
    logic [psd_pkg::CNT_W-1:0] r_cnt;
    logic [psd_pkg::IDX_W-1:0] r_idx;
    logic                      r_out_valid;
    psd_pkg::t_out_req         r_out;
    logic                      push;
    logic                      is_last;
    logic [psd_pkg::CNT_W-1:0] idx_next;

    assign idx_next = psd_pkg::CNT_W'(r_idx) + psd_pkg::CNT_W'(1);
    assign is_last  = idx_next == r_cnt;
    assign push     = r_busy && (!r_out_valid || !i_out_stall);

    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // walk through the buffered frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (push) begin
            r_busy <= !is_last;
            r_idx  <= r_idx + psd_pkg::IDX_W'(1);
        end
    end

    // frame snapshot
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_frame.words;
            r_cnt <= i_frame.count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out.channel_index  <= psd_pkg::CHIDX_W'(r_idx);
            r_out.channel_width  <= r_buf[r_idx];
            r_out.frame_channels <= r_cnt;
            r_out.last_of_frame  <= is_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_sum_decoder_top.sv =====
// top level of the ppm-sum decoder: input register, config registers and wiring
// depends on psd_pkg, psd_pulse, psd_frame, psd_emit
//
//   channel | direction | handshake            | payload
//   in      | input     | i_in_valid/o_in_stall | i_in_req  (pin level, timestamp)
//   out     | output    | o_out_valid/i_out_stall | o_out_req (one channel of a frame)
//   cfg     | input     | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// one sample per cycle while o_in_stall is low: a sample is registered, then decoded
// from the input register; a sync emits the stored frame one channel per output request,
// from a snapshot buffer, so sampling continues meanwhile
// a sample that would emit a frame while the previous one is still going out waits
// reset is synchronous, active low; the channel store is not reset
`default_nettype none

module ppm_sum_decoder_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire psd_pkg::t_in_req               i_in_req,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output psd_pkg::t_out_req                   o_out_req,
    input  wire logic                           i_cfg_we,
    input  wire logic [psd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [psd_pkg::CFG_W-1:0]      i_cfg_wdata
);

    psd_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    psd_pkg::t_in_req r_in;
    psd_pkg::t_pulse  pulse;
    psd_pkg::t_frame  frame;
    logic             emit_busy;
    logic             blocked;
    logic             adv;

    // the registered sample advances unless its frame cannot be handed over yet
    assign blocked    = frame.emit && emit_busy;
    assign adv        = r_in_valid && !blocked;
    assign o_in_stall = r_in_valid && blocked;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_threshold     <= psd_pkg::SYNC_THRESHOLD_RST;
            r_cfg.valid_low          <= psd_pkg::VALID_LOW_RST;
            r_cfg.valid_high         <= psd_pkg::VALID_HIGH_RST;
            r_cfg.min_frame_channels <= psd_pkg::MIN_FRAME_RST;
        end else if (i_cfg_we) begin
            unique case (psd_pkg::t_reg_idx'(i_cfg_idx))
                psd_pkg::REG_SYNC_THRESHOLD: r_cfg.sync_threshold <= i_cfg_wdata;
                psd_pkg::REG_VALID_LOW:      r_cfg.valid_low      <= i_cfg_wdata;
                psd_pkg::REG_VALID_HIGH:     r_cfg.valid_high     <= i_cfg_wdata;
                psd_pkg::REG_MIN_FRAME:
                    r_cfg.min_frame_channels <= i_cfg_wdata[psd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    psd_pulse u_pulse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_req   (r_in),
        .o_pulse (pulse)
    );

    psd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_pulse (pulse),
        .o_frame (frame)
    );

    psd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && frame.emit),
        .i_frame     (frame),
        .o_busy      (emit_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

`default_nettype wire

// ===== tb/tb_ppm_sum_decoder_top.sv =====
// self-checking testbench for ppm_sum_decoder_top: drives pin samples, predicts channel results
// depends on psd_pkg and the ppm_sum_decoder_top rtl
`timescale 1ns / 1ps

module tb_ppm_sum_decoder_top;

    // clock, reset and block inputs, all known from time zero
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    psd_pkg::t_in_req              i_in_req    = '0;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [psd_pkg::CFG_IDX_W-1:0] i_cfg_idx   = psd_pkg::REG_SYNC_THRESHOLD;
    logic [psd_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    psd_pkg::t_out_req             o_out_req;

    // idling percentages for both sides
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    // run statistics
    int samples_sent      = 0;
    int results_predicted = 0;
    int channels_checked  = 0;
    int settings_applied  = 0;
    int error_count       = 0;

    // sample generator position
    logic [psd_pkg::TIME_W-1:0] cur_stamp = '0;
    logic                       cur_level = 1'b0;

    // decoder model state and registers
    logic                        seen_first  = 1'b0;
    logic                        level_prev  = 1'b0;
    logic [psd_pkg::TIME_W-1:0]  edge_stamp  = '0;
    psd_pkg::t_phase             phase       = psd_pkg::PH_INITIAL;
    logic [psd_pkg::WIDTH_W-1:0] half_width  = '0;
    int                          chan_count  = 0;
    logic                        out_of_sync = 1'b0;
    logic [psd_pkg::WIDTH_W-1:0] chan_store [psd_pkg::MAX_CHANNELS];
    logic [psd_pkg::WIDTH_W-1:0] reg_sync_thr  = psd_pkg::SYNC_THRESHOLD_RST;
    logic [psd_pkg::WIDTH_W-1:0] reg_valid_lo  = psd_pkg::VALID_LOW_RST;
    logic [psd_pkg::WIDTH_W-1:0] reg_valid_hi  = psd_pkg::VALID_HIGH_RST;
    logic [psd_pkg::CNT_W-1:0]   reg_min_chans = psd_pkg::MIN_FRAME_RST;

    // channel results still owed by the block, oldest first
    psd_pkg::t_out_req expected_channels [$];

    ppm_sum_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < out_stall_pct);
    end

    // frame decoder: one measured pulse width, emits the frame on a sync
    function automatic void decode_width(input logic [psd_pkg::WIDTH_W-1:0] w);
        psd_pkg::t_out_req chan;
        if (w >= reg_sync_thr) begin
            if (!out_of_sync && chan_count >= reg_min_chans) begin
                for (int k = 0; k < chan_count && k < psd_pkg::MAX_CHANNELS; k++) begin
                    chan.channel_index  = psd_pkg::CHIDX_W'(k);
                    chan.channel_width  = chan_store[k];
                    chan.frame_channels = psd_pkg::CNT_W'(chan_count);
                    chan.last_of_frame  = (k + 1 == chan_count);
                    expected_channels.push_back(chan);
                    results_predicted++;
                end
            end
            chan_count  = 0;
            out_of_sync = 1'b0;
            return;
        end
        if (out_of_sync) return;
        // strictly inside the window is a channel
        if (w > reg_valid_lo && w < reg_valid_hi) begin
            if (chan_count < psd_pkg::MAX_CHANNELS) chan_store[chan_count] = w;
            chan_count = (chan_count + 1) & 31;
        end
        // too many channels: drop the frame until the next sync
        if (chan_count >= psd_pkg::MAX_CHANNELS) begin
            out_of_sync = 1'b1;
            chan_count  = 0;
        end
    endfunction

    // edge detection and pulse tracker for one accepted sample
    function automatic void decode_sample(input psd_pkg::t_in_req req);
        logic [psd_pkg::WIDTH_W-1:0] gap;
        if (!seen_first) begin
            seen_first = 1'b1;
            level_prev = req.pin_level;
            edge_stamp = req.sample_time;
            return;
        end
        if (req.pin_level != level_prev) begin
            gap        = psd_pkg::WIDTH_W'(req.sample_time - edge_stamp);
            edge_stamp = req.sample_time;
            case (phase)
                psd_pkg::PH_ZERO: begin
                    if (!req.pin_level) begin
                        half_width = gap;
                        phase      = psd_pkg::PH_ONE;
                    end
                end
                psd_pkg::PH_ONE: begin
                    if (req.pin_level) begin
                        phase = psd_pkg::PH_ZERO;
                        decode_width(psd_pkg::WIDTH_W'(half_width + gap));
                    end
                end
                default: phase = psd_pkg::PH_ZERO;
            endcase
        end
        level_prev = req.pin_level;
    endfunction

    // one field of a channel result
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // compare every accepted channel result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        psd_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_channels.size() == 0) begin
                $error("unexpected channel result: index %0d width %0d",
                       o_out_req.channel_index, o_out_req.channel_width);
                error_count++;
            end else begin
                want = expected_channels.pop_front();
                check_field("channel_index", want.channel_index, o_out_req.channel_index);
                check_field("channel_width", want.channel_width, o_out_req.channel_width);
                check_field("frame_channels", want.frame_channels, o_out_req.frame_channels);
                check_field("last_of_frame", want.last_of_frame, o_out_req.last_of_frame);
                channels_checked++;
            end
        end
    end

    // send one pin sample request and wait until it is taken
    task automatic send_sample(input logic lvl, input logic [psd_pkg::TIME_W-1:0] stamp);
        psd_pkg::t_in_req req;
        req.pin_level   = lvl;
        req.sample_time = stamp;
        cur_level       = lvl;
        cur_stamp       = stamp;
        @(negedge i_clk);
        while ($urandom_range(99, 0) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_sample(req);
        samples_sent++;
    endtask

    // one low-then-high pulse of the given total width, from a high level
    task automatic send_pulse(input int w);
        int                         high_part;
        logic [psd_pkg::TIME_W-1:0] fall;
        if (!cur_level) send_sample(1'b1, cur_stamp + $urandom_range(500, 50));
        high_part = $urandom_range(w, 0);
        fall      = cur_stamp + high_part;
        send_sample(1'b0, fall);
        // occasional sample with no level change inside the low half
        if ($urandom_range(99, 0) < 8)
            send_sample(1'b0, fall + $urandom_range(w - high_part, 0));
        send_sample(1'b1, fall + (w - high_part));
    endtask

    function automatic int channel_width();
        int lo, hi;
        lo = int'(reg_valid_lo) + 1;
        hi = int'(reg_valid_hi) - 1;
        if (hi > int'(reg_sync_thr) - 1) hi = int'(reg_sync_thr) - 1;
        if (lo > hi) return $urandom_range(65535, 0);
        case ($urandom_range(9, 0))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic int sync_width();
        int w;
        case ($urandom_range(9, 0))
            0:       w = reg_sync_thr;
            1:       w = 65535;
            default: w = int'(reg_sync_thr) + $urandom_range(2000, 0);
        endcase
        return (w > 65535) ? 65535 : w;
    endfunction

    // channel pulses, a few rejected ones between them, then the sync if with_sync is set
    task automatic send_frame(input int nch, input logic with_sync);
        int i;
        for (i = 0; i < nch; i++) begin
            if ($urandom_range(99, 0) < 10)
                send_pulse($urandom_range(1, 0) ? reg_valid_lo : reg_valid_hi);
            send_pulse(channel_width());
        end
        if (with_sync) send_pulse(sync_width());
    endtask

    // mostly well-formed frames, some cut short, some raw noise
    task automatic run_traffic(input int n_items, input int n_results);
        int first_sample, first_result, pick, nch, rounds;
        first_sample = samples_sent;
        first_result = results_predicted;
        rounds       = 0;
        while ((samples_sent - first_sample < n_items ||
                results_predicted - first_result < n_results) && rounds < 400) begin
            rounds++;
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                if ($urandom_range(99, 0) < 70 && reg_min_chans < psd_pkg::MAX_CHANNELS)
                    nch = $urandom_range(psd_pkg::MAX_CHANNELS - 1, reg_min_chans);
                else
                    nch = $urandom_range(psd_pkg::MAX_CHANNELS + 2, 0);
                send_frame(nch, 1'b1);
            end else if (pick < 88) begin
                send_frame($urandom_range(psd_pkg::MAX_CHANNELS - 1, 1), 1'b0);
                send_sample(1'($urandom_range(1, 0)), cur_stamp + $urandom());
            end else begin
                repeat ($urandom_range(3, 1))
                    send_sample(1'($urandom_range(1, 0)), cur_stamp + $urandom());
            end
        end
    endtask

    // stop sending and let the block drain before touching registers
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_channels.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_register(input psd_pkg::t_reg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= psd_pkg::CFG_W'(value);
        @(posedge i_clk);
        case (idx)
            psd_pkg::REG_SYNC_THRESHOLD: reg_sync_thr  = psd_pkg::WIDTH_W'(value);
            psd_pkg::REG_VALID_LOW:      reg_valid_lo  = psd_pkg::WIDTH_W'(value);
            psd_pkg::REG_VALID_HIGH:     reg_valid_hi  = psd_pkg::WIDTH_W'(value);
            psd_pkg::REG_MIN_FRAME:      reg_min_chans = psd_pkg::CNT_W'(value);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int thr, input int lo, input int hi, input int min_chans);
        wait_idle();
        write_register(psd_pkg::REG_SYNC_THRESHOLD, thr);
        write_register(psd_pkg::REG_VALID_LOW, lo);
        write_register(psd_pkg::REG_VALID_HIGH, hi);
        write_register(psd_pkg::REG_MIN_FRAME, min_chans);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // priming, first edge, wrong-direction edge, wrap, truncation, window edges
    task automatic test_tracker_directed();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        apply_settings(psd_pkg::VALID_HIGH_RST + 400, psd_pkg::VALID_LOW_RST,
                       psd_pkg::VALID_HIGH_RST, 1);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0000);
        send_sample(1'b0, 32'd100);
        send_sample(1'b1, 32'd130);
        // single-channel frame
        send_pulse(1500);
        send_pulse(3000);
        // interval beyond 16 bits, empty frame sync
        send_sample(1'b0, cur_stamp + 70000);
        send_sample(1'b1, cur_stamp + 1000);
        // window limits just inside, largest sync
        send_pulse(psd_pkg::VALID_LOW_RST + 1);
        send_pulse(psd_pkg::VALID_HIGH_RST - 1);
        send_pulse(1500);
        send_pulse(65535);
        // window limits themselves are rejected, exact threshold syncs
        send_pulse(psd_pkg::VALID_LOW_RST);
        send_pulse(psd_pkg::VALID_HIGH_RST);
        send_pulse(psd_pkg::VALID_HIGH_RST + 400);
    endtask

    task automatic test_default_frames();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        apply_settings(psd_pkg::SYNC_THRESHOLD_RST, psd_pkg::VALID_LOW_RST,
                       psd_pkg::VALID_HIGH_RST, psd_pkg::MIN_FRAME_RST);
        run_traffic(25, 8);
    endtask

    task automatic test_sender_gaps();
        in_idle_pct   = 46;
        out_stall_pct = 0;
        apply_settings(3000, 900, 2100, 3);
        run_traffic(15, 5);
    endtask

    task automatic test_receiver_stalls();
        in_idle_pct   = 0;
        out_stall_pct = 46;
        apply_settings(2000, 500, 1900, psd_pkg::MAX_CHANNELS - 1);
        run_traffic(15, 7);
    endtask

    // register extremes: threshold, window and frame size at both ends
    task automatic test_register_extremes();
        in_idle_pct   = 9;
        out_stall_pct = 9;
        apply_settings(65535, 0, 65535, 16);
        run_traffic(6, 0);
        apply_settings(0, 65535, 0, 1);
        run_traffic(6, 0);
    endtask

    // watchdog
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : main_sequence
        int drain;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_tracker_directed();
        test_default_frames();
        test_sender_gaps();
        test_receiver_stalls();
        test_register_extremes();

        // let outstanding channels arrive, then let the block run quiet
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain = 0;
        while (expected_channels.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_channels.size() != 0) begin
            $error("%0d expected channel results never arrived", expected_channels.size());
            error_count++;
        end

        $display("run covered %0d pin samples under %0d register settings, %0d channels checked",
                 samples_sent, settings_applied, channels_checked);
        $display("idling: none, sender gaps, receiver stalls and both together");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
